// ===== hw/rtl/rrcs_pkg.sv =====
package rrcs_pkg;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned IdxW     = $clog2(MaxProcs);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned ValW     = 16;
  localparam int unsigned TimeW    = 21;
  localparam int unsigned SumW     = 25;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpStep  = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic {
    AluAdd = 1'b0,
    AluSub = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [SumW-1:0]  a;
    logic [SumW-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [SumW-1:0]  res;
    logic             borrow;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StLdShift,
    StAdmit,
    StJump,
    StPop,
    StLen,
    StEnd,
    StRem,
    StTurn,
    StWait,
    StResp,
    StSumW,
    StSumT,
    StSumR,
    StOut
  } state_e;

endpackage

// ===== hw/rtl/rrcs_alu.sv =====
module rrcs_alu (
  input  rrcs_pkg::alu_req_t req_i,
  output rrcs_pkg::alu_rsp_t rsp_o
);
  import rrcs_pkg::*;

  logic [SumW-1:0] b_op;
  logic [SumW:0]   sum;

  // one adder serves add, subtract and compare
  assign b_op = (req_i.op == AluSub) ? ~req_i.b : req_i.b;
  assign sum  = {1'b0, req_i.a} + {1'b0, b_op} + {{SumW{1'b0}}, (req_i.op == AluSub)};

  assign rsp_o.res    = sum[SumW-1:0];
  assign rsp_o.borrow = (req_i.op == AluSub) & ~sum[SumW];

endmodule

// ===== hw/rtl/round_robin_cpu_scheduler.sv =====
// channel   | dir | handshake                   | content
// s_axis    | in  | s_axis_tvalid/tready        | tdata: arrive_time, burst_length; tuser: op
// m_axis    | out | m_axis_tvalid/tready        | tdata: slice fields and totals;
//           |     |                             | tuser: finished; tlast: all_done
// cfg       | in  | cfg_valid_i/cfg_ready_o     | quantum (always ready)
//
// a load writes the tables, then the insertion sort shifts up each entry that arrives
// later than the new one and places the new entry in the gap
// a step that yields a slice runs fixed sequencer steps on the shared adder plus the
// admit passes, which take in each arrival up to the time limit; a step with nothing
// to run returns straight to idle
// clear and unused ops return straight to idle; reset is asynchronous, active low
// a finished result sits in the output register while the next transaction is
// worked on; the sequencer only stalls if a second result is ready before the first
// is taken
module round_robin_cpu_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrcs_pkg::ValW-1:0]     cfg_data_i,       // quantum
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,     // arrive_time, burst_length
  input  logic [1:0]                    s_axis_tuser,     // op
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // proc_id, slice_start, slice_end, slice_len, turnaround, wait_res, response,
  // total_wait, total_turnaround, total_response
  output logic [199:0]                  m_axis_tdata,
  output logic                          m_axis_tuser,     // finished
  output logic                          m_axis_tlast      // all_done
);
  import rrcs_pkg::*;

  // per-process tables, one read address per table each cycle
  logic [ValW-1:0]  arr_mem   [MaxProcs];
  logic [ValW-1:0]  orig_mem  [MaxProcs];
  logic [ValW-1:0]  rem_mem   [MaxProcs];
  logic [TimeW-1:0] first_mem [MaxProcs];
  logic [IdxW-1:0]  order_mem [MaxProcs];
  logic [IdxW-1:0]  queue_mem [MaxProcs];
  logic [MaxProcs-1:0] started_q;

  state_e state_q, state_d, ret_q;

  logic [ValW-1:0]  quantum_q;
  logic [IdxW-1:0]  head_q;
  logic [CntW-1:0]  qcnt_q;
  logic [CntW-1:0]  loaded_q, admitted_q, finished_q;
  logic [TimeW-1:0] cur_q, limit_q, start_q, end_q, turn_q, wait_q, resp_q;
  logic [SumW-1:0]  sumw_q, sumt_q, sumr_q;
  logic [ValW-1:0]  len_q, a_q;
  logic [IdxW-1:0]  pos_q, id_q;
  logic             done_q;

  logic [199:0]     out_data_q;
  logic             out_valid_q, out_fin_q, out_last_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [IdxW-1:0] order_addr, arr_addr;
  logic [IdxW-1:0] order_rd;
  logic [ValW-1:0] arr_rd, rem_rd, qnt;
  logic            admit_more, ld_shift, in_fire, out_free;
  op_e             op_in;

  rrcs_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign op_in         = op_e'(s_axis_tuser);
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign qnt           = (quantum_q == '0) ? ValW'(1) : quantum_q;

  // table read addresses
  always_comb begin
    order_addr = (state_q == StLdShift) ? (pos_q - IdxW'(1)) : admitted_q[IdxW-1:0];
    order_rd   = order_mem[order_addr];
    case (state_q)
      StLdShift, StAdmit, StJump: arr_addr = order_rd;
      default:                    arr_addr = id_q;
    endcase
    arr_rd = arr_mem[arr_addr];
    rem_rd = rem_mem[id_q];
  end

  // shared adder operands
  always_comb begin
    alu_req.op = AluSub;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state_q)
      StLdShift: begin
        alu_req.a = SumW'(a_q);
        alu_req.b = SumW'(arr_rd);
      end
      StAdmit: begin
        alu_req.a = SumW'(limit_q);
        alu_req.b = SumW'(arr_rd);
      end
      StLen: begin
        alu_req.a = SumW'(rem_rd);
        alu_req.b = SumW'(qnt);
      end
      StEnd: begin
        alu_req.op = AluAdd;
        alu_req.a  = SumW'(start_q);
        alu_req.b  = SumW'(len_q);
      end
      StRem: begin
        alu_req.a = SumW'(rem_rd);
        alu_req.b = SumW'(len_q);
      end
      StTurn: begin
        alu_req.a = SumW'(end_q);
        alu_req.b = SumW'(arr_rd);
      end
      StWait: begin
        alu_req.a = SumW'(turn_q);
        alu_req.b = SumW'(orig_mem[id_q]);
      end
      StResp: begin
        alu_req.a = SumW'(first_mem[id_q]);
        alu_req.b = SumW'(arr_rd);
      end
      StSumW: begin
        alu_req.op = AluAdd;
        alu_req.a  = sumw_q;
        alu_req.b  = SumW'(wait_q);
      end
      StSumT: begin
        alu_req.op = AluAdd;
        alu_req.a  = sumt_q;
        alu_req.b  = SumW'(turn_q);
      end
      StSumR: begin
        alu_req.op = AluAdd;
        alu_req.a  = sumr_q;
        alu_req.b  = SumW'(resp_q);
      end
      default: ;
    endcase
  end

  // arrival at or before the limit: no borrow on limit minus arrival
  assign admit_more = (admitted_q < loaded_q) & ~alu_rsp.borrow;
  // earlier entry arrives later than the new one: shift it up
  assign ld_shift   = ({1'b0, pos_q} > admitted_q) & alu_rsp.borrow;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          case (op_in)
            OpLoad:  state_d = (loaded_q >= CntW'(MaxProcs)) ? StIdle : StLdShift;
            OpStep:  state_d = (finished_q >= loaded_q) ? StIdle : StAdmit;
            default: state_d = StIdle;
          endcase
        end
      end
      StLdShift: state_d = ld_shift ? StLdShift : StIdle;
      StAdmit:   state_d = admit_more ? StAdmit : ret_q;
      StJump: begin
        if (qcnt_q == '0 && admitted_q < loaded_q) state_d = StAdmit;
        else                                        state_d = StPop;
      end
      StPop:  state_d = (qcnt_q == '0) ? StIdle : StLen;
      StLen:  state_d = StEnd;
      StEnd:  state_d = StAdmit;
      StRem:  state_d = (alu_rsp.res[ValW-1:0] == '0) ? StTurn : StOut;
      StTurn: state_d = StWait;
      StWait: state_d = StResp;
      StResp: state_d = StSumW;
      StSumW: state_d = StSumT;
      StSumT: state_d = StSumR;
      StSumR: state_d = StOut;
      StOut:  state_d = out_free ? StIdle : StOut;
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StJump;
      quantum_q   <= ValW'(2);
      started_q   <= '0;
      head_q      <= '0;
      qcnt_q      <= '0;
      loaded_q    <= '0;
      admitted_q  <= '0;
      finished_q  <= '0;
      cur_q       <= '0;
      sumw_q      <= '0;
      sumt_q      <= '0;
      sumr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) quantum_q <= cfg_data_i;
      // output register fills from the sequencer, drains on acceptance
      if (state_q == StOut && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)           out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            case (op_in)
              OpLoad: begin
                if (loaded_q < CntW'(MaxProcs)) started_q[loaded_q[IdxW-1:0]] <= 1'b0;
              end
              OpStep: ret_q <= StJump;
              OpClear: begin
                started_q  <= '0;
                head_q     <= '0;
                qcnt_q     <= '0;
                loaded_q   <= '0;
                admitted_q <= '0;
                finished_q <= '0;
                cur_q      <= '0;
                sumw_q     <= '0;
                sumt_q     <= '0;
                sumr_q     <= '0;
              end
              default: ;
            endcase
          end
        end
        StLdShift: if (!ld_shift) loaded_q <= loaded_q + CntW'(1);
        StAdmit: begin
          if (admit_more) begin
            admitted_q <= admitted_q + CntW'(1);
            if (qcnt_q < CntW'(MaxProcs)) qcnt_q <= qcnt_q + CntW'(1);
          end
        end
        StJump: begin
          if (qcnt_q == '0 && admitted_q < loaded_q) begin
            cur_q <= TimeW'(arr_rd);
            ret_q <= StPop;
          end
        end
        StPop: begin
          if (qcnt_q != '0) begin
            head_q <= head_q + IdxW'(1);
            qcnt_q <= qcnt_q - CntW'(1);
          end
        end
        StLen: started_q[id_q] <= 1'b1;
        StEnd: ret_q <= StRem;
        StRem: begin
          cur_q <= end_q;
          if (alu_rsp.res[ValW-1:0] == '0) finished_q <= finished_q + CntW'(1);
          else                              qcnt_q <= qcnt_q + CntW'(1);
        end
        StSumW: sumw_q <= alu_rsp.res;
        StSumT: sumt_q <= alu_rsp.res;
        StSumR: sumr_q <= alu_rsp.res;
        default: ;
      endcase
    end
  end

  // tables and payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_fire && op_in == OpLoad && loaded_q < CntW'(MaxProcs)) begin
          arr_mem[loaded_q[IdxW-1:0]]  <= s_axis_tdata[15:0];
          orig_mem[loaded_q[IdxW-1:0]] <= s_axis_tdata[31:16];
          rem_mem[loaded_q[IdxW-1:0]]  <= s_axis_tdata[31:16];
          a_q   <= s_axis_tdata[15:0];
          pos_q <= loaded_q[IdxW-1:0];
        end
        if (in_fire && op_in == OpStep) limit_q <= cur_q;
      end
      StLdShift: begin
        if (ld_shift) begin
          order_mem[pos_q] <= order_rd;
          pos_q            <= pos_q - IdxW'(1);
        end else begin
          order_mem[pos_q] <= loaded_q[IdxW-1:0];
        end
      end
      StAdmit: begin
        if (admit_more && qcnt_q < CntW'(MaxProcs))
          queue_mem[head_q + qcnt_q[IdxW-1:0]] <= order_rd;
      end
      StJump: limit_q <= TimeW'(arr_rd);
      StPop: begin
        id_q   <= queue_mem[head_q];
        done_q <= 1'b0;
      end
      StLen: begin
        start_q <= cur_q;
        len_q   <= alu_rsp.borrow ? rem_rd : qnt;
        if (!started_q[id_q]) first_mem[id_q] <= cur_q;
      end
      StEnd: begin
        end_q   <= alu_rsp.res[TimeW-1:0];
        limit_q <= alu_rsp.res[TimeW-1:0];
      end
      StRem: begin
        rem_mem[id_q] <= alu_rsp.res[ValW-1:0];
        if (alu_rsp.res[ValW-1:0] == '0) done_q <= 1'b1;
        else queue_mem[head_q + qcnt_q[IdxW-1:0]] <= id_q;
      end
      StTurn: turn_q <= alu_rsp.res[TimeW-1:0];
      StWait: wait_q <= alu_rsp.res[TimeW-1:0];
      StResp: resp_q <= alu_rsp.res[TimeW-1:0];
      StOut: begin
        if (out_free) begin
          out_data_q <= {sumr_q, sumt_q, sumw_q,
                         done_q ? resp_q : TimeW'(0),
                         done_q ? wait_q : TimeW'(0),
                         done_q ? turn_q : TimeW'(0),
                         len_q, end_q, start_q, id_q};
          out_fin_q  <= done_q;
          out_last_q <= (finished_q >= loaded_q);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fin_q;
  assign m_axis_tlast  = out_last_q;

endmodule
